/* hdl/seek_goal_kinematic_step_unit_macros.svh */
// assertion macros for the seek goal kinematic step unit
`ifndef SEEK_GOAL_KINEMATIC_STEP_UNIT_MACROS_SVH
`define SEEK_GOAL_KINEMATIC_STEP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SGK_ASSERT_IMM(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgk check failed");
// next-cycle implication
`define SGK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgk check failed");
`else
`define SGK_ASSERT_IMM(label, clk, rst_n, ante, cons)
`define SGK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/sgk_pkg.sv */
// shared types and codes for the seek goal kinematic step unit
package sgk_pkg;

    // operations of the shared arithmetic unit
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    localparam int CNT_BITS = 8;

    // command to the arithmetic unit
    typedef struct packed {
        logic                start;
        logic [1:0]          op;
        logic [CNT_BITS-1:0] cnt;
    } t_alu_ctl;

endpackage

/* hdl/seek_goal_kinematic_step_unit.sv */
// Seek steering with arrival for one point: holds position, velocity and an arrived flag
// in signed fixed point and answers every item with the state after it. All arithmetic
// runs through one shared unit that resolves one bit per cycle, so an item holds the
// block until its steps are done: load and unused commands go straight to the result,
// a move multiplies twice, and a steer squares twice and takes a square root, then stops
// on arrival, else adds one multiply and two divides, plus two more multiplies when the
// goal is out of one-step reach. The divider, with 2W+32 quotient bits (W = WORD_BITS),
// is the longest step. No new item is taken until the result has been handed off.
`include "seek_goal_kinematic_step_unit_macros.svh"
module seek_goal_kinematic_step_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration writes
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data,
    // input items
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,  // in_x, in_y, in_vx, in_vy
    input  logic [1:0]   i_s_axis_tuser,  // cmd
    // result items
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [135:0] o_m_axis_tdata   // out_x, out_y, out_vx, out_vy, arrived
);
    localparam int W = WORD_BITS;
    localparam int A = 2 * W + 32;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STEER = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;

    localparam logic [1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [1:0] REG_STEP_TIME = 2'd1;
    localparam logic [1:0] REG_ARRIVE    = 2'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_OUT  = 4'd1;
    localparam logic [3:0] S_WAIT = 4'd2;
    localparam logic [3:0] S_MV_X = 4'd3;
    localparam logic [3:0] S_MV_Y = 4'd4;
    localparam logic [3:0] S_MV_E = 4'd5;
    localparam logic [3:0] S_ST0  = 4'd6;
    localparam logic [3:0] S_ST1  = 4'd7;
    localparam logic [3:0] S_ST2  = 4'd8;
    localparam logic [3:0] S_ST3  = 4'd9;
    localparam logic [3:0] S_ST4  = 4'd10;
    localparam logic [3:0] S_ST5  = 4'd11;
    localparam logic [3:0] S_ST6  = 4'd12;
    localparam logic [3:0] S_ST7  = 4'd13;
    localparam logic [3:0] S_ST8  = 4'd14;

    logic [3:0]     r_state, n_state, r_ret, n_ret;
    logic [W-1:0]   r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [W-1:0]   r_vel_x, n_vel_x, r_vel_y, n_vel_y;
    logic           r_done, n_done;
    logic [30:0]    r_max_speed;
    logic [15:0]    r_step, r_arrive;
    logic [W-1:0]   r_gvx, n_gvx, r_gvy, n_gvy;
    logic [W-1:0]   r_mx, n_mx, r_my, n_my;
    logic           r_neg_x, n_neg_x, r_neg_y, n_neg_y;
    logic [2*W-1:0] r_sum, n_sum;
    logic [W-1:0]   r_dist, n_dist;
    logic           r_reach, n_reach;

    sgk_pkg::t_alu_ctl alu_ctl;
    logic [A-1:0]      alu_a;
    logic [W-1:0]      alu_b;
    logic              alu_busy;
    logic [A-1:0]      alu_res;

    logic [W-1:0]   in_x, in_y, in_vx, in_vy, dx, dy;
    logic           reach;
    logic           load_acc;

    // magnitude of a signed word
    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    // sign and magnitude back to a word, saturating
    function automatic logic [W-1:0] f_sat(input logic neg, input logic [A-1:0] q);
        logic [A-1:0] lim;
        logic [A-1:0] m;
        lim = A'(1) << (W - 1);
        m   = q;
        if (!neg && q > lim - A'(1)) begin
            m = lim - A'(1);
        end else if (neg && q > lim) begin
            m = lim;
        end
        return neg ? W'(-m) : W'(m);
    endfunction

    // position plus dt times velocity, floor of the scaled step
    function automatic logic [W-1:0] f_adv(input logic [W-1:0] p, input logic neg,
                                           input logic [A-1:0] prod);
        logic [A-1:0] t;
        logic [W-1:0] q;
        t = neg ? prod + A'(16'hFFFF) : prod;
        q = W'(t >> 16);
        return neg ? p - q : p + q;
    endfunction

    assign in_x  = W'(signed'(i_s_axis_tdata[31:0]));
    assign in_y  = W'(signed'(i_s_axis_tdata[63:32]));
    assign in_vx = W'(signed'(i_s_axis_tdata[95:64]));
    assign in_vy = W'(signed'(i_s_axis_tdata[127:96]));
    assign dx    = in_x - r_pos_x;
    assign dy    = in_y - r_pos_y;
    assign reach = (r_step != 16'd0) && (A'(r_dist) <= (alu_res >> 16));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_vel_x = r_vel_x;
        n_vel_y = r_vel_y;
        n_done  = r_done;
        n_gvx   = r_gvx;
        n_gvy   = r_gvy;
        n_mx    = r_mx;
        n_my    = r_my;
        n_neg_x = r_neg_x;
        n_neg_y = r_neg_y;
        n_sum   = r_sum;
        n_dist  = r_dist;
        n_reach = r_reach;
        alu_ctl = '0;
        alu_a   = '0;
        alu_b   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (i_s_axis_tuser)
                        CMD_LOAD: begin
                            n_pos_x = in_x;
                            n_pos_y = in_y;
                            n_vel_x = in_vx;
                            n_vel_y = in_vy;
                            n_done  = 1'b0;
                            n_state = S_OUT;
                        end
                        CMD_STEER: begin
                            n_gvx   = in_vx;
                            n_gvy   = in_vy;
                            n_neg_x = dx[W-1];
                            n_neg_y = dy[W-1];
                            n_mx    = f_mag(dx);
                            n_my    = f_mag(dy);
                            n_state = S_ST0;
                        end
                        CMD_MOVE: n_state = S_MV_X;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                if (!alu_busy) begin
                    n_state = r_ret;
                end
            end
            // move: dt times each velocity
            S_MV_X: begin
                alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_MUL, cnt: sgk_pkg::CNT_BITS'(16)};
                alu_a   = A'(f_mag(r_vel_x));
                alu_b   = W'(r_step);
                n_ret   = S_MV_Y;
                n_state = S_WAIT;
            end
            S_MV_Y: begin
                n_pos_x = f_adv(r_pos_x, r_vel_x[W-1], alu_res);
                alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_MUL, cnt: sgk_pkg::CNT_BITS'(16)};
                alu_a   = A'(f_mag(r_vel_y));
                alu_b   = W'(r_step);
                n_ret   = S_MV_E;
                n_state = S_WAIT;
            end
            S_MV_E: begin
                n_pos_y = f_adv(r_pos_y, r_vel_y[W-1], alu_res);
                n_state = S_OUT;
            end
            // steer: squared distance
            S_ST0: begin
                alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_MUL, cnt: sgk_pkg::CNT_BITS'(W)};
                alu_a   = A'(r_mx);
                alu_b   = r_mx;
                n_ret   = S_ST1;
                n_state = S_WAIT;
            end
            S_ST1: begin
                n_sum   = alu_res[2*W-1:0];
                alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_MUL, cnt: sgk_pkg::CNT_BITS'(W)};
                alu_a   = A'(r_my);
                alu_b   = r_my;
                n_ret   = S_ST2;
                n_state = S_WAIT;
            end
            S_ST2: begin
                alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_SQRT, cnt: sgk_pkg::CNT_BITS'(W)};
                alu_a   = A'(r_sum + alu_res[2*W-1:0]);
                n_ret   = S_ST3;
                n_state = S_WAIT;
            end
            // arrival test, then one-step reach limit
            S_ST3: begin
                n_dist = alu_res[W-1:0];
                if (alu_res[W-1:0] <= W'(r_arrive)) begin
                    n_vel_x = r_gvx;
                    n_vel_y = r_gvy;
                    n_done  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_MUL,
                                cnt: sgk_pkg::CNT_BITS'(16)};
                    alu_a   = A'(r_max_speed);
                    alu_b   = W'(r_step);
                    n_ret   = S_ST4;
                    n_state = S_WAIT;
                end
            end
            S_ST4: begin
                n_reach = reach;
                if (reach) begin
                    alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_DIV, cnt: sgk_pkg::CNT_BITS'(A)};
                    alu_a   = A'(r_mx) << 16;
                    alu_b   = W'(r_step);
                    n_ret   = S_ST6;
                end else begin
                    alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_MUL, cnt: sgk_pkg::CNT_BITS'(W)};
                    alu_a   = A'(r_max_speed);
                    alu_b   = r_mx;
                    n_ret   = S_ST5;
                end
                n_state = S_WAIT;
            end
            S_ST5: begin
                alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_DIV, cnt: sgk_pkg::CNT_BITS'(A)};
                alu_a   = alu_res;
                alu_b   = r_dist;
                n_ret   = S_ST6;
                n_state = S_WAIT;
            end
            S_ST6: begin
                n_vel_x = f_sat(r_neg_x, alu_res);
                if (r_reach) begin
                    alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_DIV, cnt: sgk_pkg::CNT_BITS'(A)};
                    alu_a   = A'(r_my) << 16;
                    alu_b   = W'(r_step);
                    n_ret   = S_ST8;
                end else begin
                    alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_MUL, cnt: sgk_pkg::CNT_BITS'(W)};
                    alu_a   = A'(r_max_speed);
                    alu_b   = r_my;
                    n_ret   = S_ST7;
                end
                n_state = S_WAIT;
            end
            S_ST7: begin
                alu_ctl = '{start: 1'b1, op: sgk_pkg::OP_DIV, cnt: sgk_pkg::CNT_BITS'(A)};
                alu_a   = alu_res;
                alu_b   = r_dist;
                n_ret   = S_ST8;
                n_state = S_WAIT;
            end
            S_ST8: begin
                n_vel_y = f_sat(r_neg_y, alu_res);
                n_state = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_done      <= 1'b0;
            r_max_speed <= 31'd6553600;
            r_step      <= 16'd1092;
            r_arrive    <= 16'd3277;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_vel_x <= n_vel_x;
            r_vel_y <= n_vel_y;
            r_done  <= n_done;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MAX_SPEED: r_max_speed <= i_cfg_data;
                    REG_STEP_TIME: r_step      <= i_cfg_data[15:0];
                    REG_ARRIVE:    r_arrive    <= i_cfg_data[15:0];
                    default:       r_arrive    <= r_arrive;
                endcase
            end
        end
        r_gvx   <= n_gvx;
        r_gvy   <= n_gvy;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_sum   <= n_sum;
        r_dist  <= n_dist;
        r_reach <= n_reach;
    end

    // shared arithmetic unit
    sgk_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_busy  (alu_busy),
        .o_res   (alu_res)
    );

    // handshake and result item
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {7'd0, r_done,
                              32'(signed'(r_vel_y)), 32'(signed'(r_vel_x)),
                              32'(signed'(r_pos_y)), 32'(signed'(r_pos_x))};

    // accepted load item
    assign load_acc = o_s_axis_tready && i_s_axis_tvalid && (i_s_axis_tuser == CMD_LOAD);

    // checks
    `SGK_ASSERT_IMM(a_one_item, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready)
    `SGK_ASSERT_IMM(a_busy_in_wait, i_clk, i_rst_n, alu_busy, r_state == S_WAIT)
    `SGK_ASSERT_NXT(a_load_result, i_clk, i_rst_n, load_acc, o_m_axis_tvalid && !r_done)

endmodule

/* hdl/sgk_alu.sv */
// shared iterative multiply, divide and square root unit, one bit per cycle
module sgk_alu #(
    parameter int WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sgk_pkg::t_alu_ctl         i_ctl,
    input  logic [2*WORD_BITS+31:0]   i_a,
    input  logic [WORD_BITS-1:0]      i_b,
    output logic                      o_busy,
    output logic [2*WORD_BITS+31:0]   o_res
);
    localparam int W  = WORD_BITS;
    localparam int A  = 2 * W + 32;
    localparam int RW = W + 3;

    logic [A-1:0]                 r_acc, n_acc;
    logic [A-1:0]                 r_sh, n_sh;
    logic [W-1:0]                 r_b, n_b;
    logic [RW-1:0]                r_rem, n_rem;
    logic [sgk_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic [1:0]                   r_op, n_op;
    logic [W+1:0]                 div_t;
    logic [RW-1:0]                sq_t;
    logic [RW-1:0]                sq_trial;

    // one step of the selected operation
    always_comb begin
        n_acc    = r_acc;
        n_sh     = r_sh;
        n_b      = r_b;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_op     = r_op;
        div_t    = {r_rem[W:0], r_sh[A-1]};
        sq_t     = {r_rem[RW-3:0], r_sh[A-1:A-2]};
        sq_trial = {1'b0, r_acc[W-1:0], 2'b01};
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_cnt  = i_ctl.cnt;
            n_acc  = '0;
            n_rem  = '0;
            n_b    = i_b;
            if (i_ctl.op == sgk_pkg::OP_SQRT) begin
                n_sh = {i_a[2*W-1:0], 32'd0};
            end else begin
                n_sh = i_a;
            end
        end else if (r_busy) begin
            case (r_op)
                sgk_pkg::OP_MUL: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_sh;
                    end
                    n_sh = r_sh << 1;
                    n_b  = r_b >> 1;
                end
                sgk_pkg::OP_DIV: begin
                    if (div_t >= {2'b00, r_b}) begin
                        n_rem = RW'(div_t - {2'b00, r_b});
                        n_acc = {r_acc[A-2:0], 1'b1};
                    end else begin
                        n_rem = RW'(div_t);
                        n_acc = {r_acc[A-2:0], 1'b0};
                    end
                    n_sh = r_sh << 1;
                end
                sgk_pkg::OP_SQRT: begin
                    if (sq_t >= sq_trial) begin
                        n_rem = sq_t - sq_trial;
                        n_acc = {r_acc[A-2:0], 1'b1};
                    end else begin
                        n_rem = sq_t;
                        n_acc = {r_acc[A-2:0], 1'b0};
                    end
                    n_sh = r_sh << 2;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == sgk_pkg::CNT_BITS'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_op   <= sgk_pkg::OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_b   <= n_b;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_res  = r_acc;

endmodule
